[hw/rtl/pip_pkg.sv]
// shared types and constants for the point-in-polygon ray-cast block
`default_nettype none
package pip_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = CoordW + 1;
	localparam int ProdW  = 2 * DiffW;
	localparam int DataW  = (CoordW > 32) ? 64 : 32;
	localparam int AddrW  = (DataW == 64) ? 4 : 3;

	// power of two, so the queue pointers wrap by themselves
	localparam int QDepth = 2;
	localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int CntW   = $clog2(QDepth + 1);

	localparam logic RegPointX = 1'b0;
	localparam logic RegPointY = 1'b1;

	typedef logic signed [CoordW-1:0] coord_t;

	typedef struct packed {
		coord_t p1x;
		coord_t p1y;
		coord_t p2x;
		coord_t p2y;
		logic   fin;
	} edge_job_t;

	typedef struct packed {
		logic push;
		logic full;
	} q_wr_t;

	typedef struct packed {
		logic pop;
		logic valid;
	} q_rd_t;

endpackage
`default_nettype wire

[hw/rtl/pip_front.sv]
// front end: takes vertex beats and turns them into edge jobs
`default_nettype none
module pip_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire pip_pkg::coord_t       vertex_x,
	input  wire pip_pkg::coord_t       vertex_y,
	input  wire logic                  last_vertex,
	output pip_pkg::q_wr_t             q_wr,
	input  wire logic                  q_full,
	output pip_pkg::edge_job_t         q_job
);

	pip_pkg::coord_t    first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic               started_q;
	logic               pend_a_q, pend_b_q;
	pip_pkg::edge_job_t job_a_q, job_b_q;
	logic               accept;

	assign in_ready = !pend_a_q && !pend_b_q;
	assign accept   = in_valid && in_ready;

	always_comb begin
		q_wr.full = q_full;
		q_wr.push = (pend_a_q || pend_b_q) && !q_full;
		q_job     = pend_a_q ? job_a_q : job_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pend_a_q  <= 1'b0;
			pend_b_q  <= 1'b0;
			first_x_q <= '0;
			first_y_q <= '0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
		end else begin
			if (q_wr.push) begin
				if (pend_a_q) begin
					pend_a_q <= 1'b0;
				end else begin
					pend_b_q <= 1'b0;
				end
			end
			if (accept) begin
				pend_a_q  <= started_q;
				pend_b_q  <= last_vertex;
				started_q <= !last_vertex;
				prev_x_q  <= vertex_x;
				prev_y_q  <= vertex_y;
				if (!started_q) begin
					first_x_q <= vertex_x;
					first_y_q <= vertex_y;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_a_q.p1x <= prev_x_q;
			job_a_q.p1y <= prev_y_q;
			job_a_q.p2x <= vertex_x;
			job_a_q.p2y <= vertex_y;
			job_a_q.fin <= 1'b0;
			// closing edge back to the first vertex
			job_b_q.p1x <= vertex_x;
			job_b_q.p1y <= vertex_y;
			job_b_q.p2x <= started_q ? first_x_q : vertex_x;
			job_b_q.p2y <= started_q ? first_y_q : vertex_y;
			job_b_q.fin <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_last_queues_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_vertex) |=> pend_b_q)
		else $error("closing edge not queued after last vertex");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready || (!$past(started_q) && !$past(last_vertex)))
		else $error("front accepted while edge jobs pending");
`endif

endmodule
`default_nettype wire

[hw/rtl/pip_fifo.sv]
// short edge-job queue between front and back
`default_nettype none
module pip_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pip_pkg::q_wr_t     q_wr,
	input  wire pip_pkg::edge_job_t wr_job,
	output logic                    full,
	input  wire logic               pop,
	output pip_pkg::q_rd_t          q_rd,
	output pip_pkg::edge_job_t      rd_job
);

	pip_pkg::edge_job_t          mem_q [pip_pkg::QDepth];
	logic [pip_pkg::PtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [pip_pkg::CntW-1:0]    count_q;
	logic                        do_push, do_pop;

	assign full    = (count_q == pip_pkg::CntW'(pip_pkg::QDepth));
	assign do_push = q_wr.push && !full;
	assign do_pop  = pop && (count_q != '0);

	always_comb begin
		q_rd.valid = (count_q != '0);
		q_rd.pop   = do_pop;
		rd_job     = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr.push |-> !full)
		else $error("edge job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("edge job popped from empty queue");
`endif

endmodule
`default_nettype wire

[hw/rtl/pip_back.sv]
// back end: exact crossing test per edge on one shared multiplier, parity and result
`default_nettype none
module pip_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pip_pkg::coord_t    point_x,
	input  wire pip_pkg::coord_t    point_y,
	input  wire pip_pkg::q_rd_t     q_rd,
	input  wire pip_pkg::edge_job_t job,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    inside_res
);

	typedef enum logic [1:0] {S_IDLE, S_MUL1, S_MUL2, S_CMP} state_t;

	state_t                              state_q;
	logic                                parity_q, out_valid_q, inside_res_q;
	logic                                fin_q, cond_q, vert_q;
	logic signed [pip_pkg::DiffW-1:0]    a_q, b_q, c_q, d_q;
	logic signed [pip_pkg::ProdW-1:0]    prod1_q, prod2_q;

	logic signed [pip_pkg::DiffW-1:0]    ax, ay, dx, dy, mul_a, mul_b;
	logic signed [pip_pkg::ProdW-1:0]    prod;
	pip_pkg::coord_t                     ylo, yhi, xhi;
	logic                                cond, advance, new_parity;

	assign pop        = (state_q == S_IDLE) && q_rd.valid;
	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;

	always_comb begin
		ylo  = (job.p1y < job.p2y) ? job.p1y : job.p2y;
		yhi  = (job.p1y < job.p2y) ? job.p2y : job.p1y;
		xhi  = (job.p1x < job.p2x) ? job.p2x : job.p1x;
		cond = (point_y > ylo) && (point_y <= yhi) && (point_x <= xhi);
		ax   = pip_pkg::DiffW'(point_x) - pip_pkg::DiffW'(job.p1x);
		ay   = pip_pkg::DiffW'(point_y) - pip_pkg::DiffW'(job.p1y);
		dx   = pip_pkg::DiffW'(job.p2x) - pip_pkg::DiffW'(job.p1x);
		dy   = pip_pkg::DiffW'(job.p2y) - pip_pkg::DiffW'(job.p1y);
	end

	always_comb begin
		mul_a = (state_q == S_MUL1) ? a_q : c_q;
		mul_b = (state_q == S_MUL1) ? b_q : d_q;
		prod  = mul_a * mul_b;
	end

	assign advance    = !fin_q || !out_valid_q || out_ready;
	assign new_parity = parity_q ^ (cond_q && (vert_q || (prod1_q <= prod2_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			parity_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			inside_res_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(state_q == S_CMP && fin_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: begin
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (advance) begin
						state_q <= S_IDLE;
						if (fin_q) begin
							out_valid_q  <= 1'b1;
							inside_res_q <= new_parity;
							parity_q     <= 1'b0;
						end else begin
							parity_q <= new_parity;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			fin_q  <= job.fin;
			cond_q <= cond;
			vert_q <= (job.p1x == job.p2x);
			// comparison direction follows the sign of dy
			if (dy > 0) begin
				a_q <= ax;
				b_q <= dy;
				c_q <= ay;
				d_q <= dx;
			end else begin
				a_q <= ay;
				b_q <= dx;
				c_q <= ax;
				d_q <= dy;
			end
		end
		if (state_q == S_MUL1) begin
			prod1_q <= prod;
		end
		if (state_q == S_MUL2) begin
			prod2_q <= prod;
		end
	end

`ifndef ASSERT_OFF
	a_result_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_CMP))
		else $error("result raised outside compare step");
	a_parity_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP && fin_q && advance) |=> !parity_q)
		else $error("parity not cleared after result");
	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd.pop |-> (state_q == S_IDLE))
		else $error("edge job taken while busy");
`endif

endmodule
`default_nettype wire

[hw/rtl/point_in_polygon_ray_cast.sv]
// top level of the even-odd ray-cast point-in-polygon test
// a last vertex beat is registered as edge jobs in the front and queued; the back end takes one job at a time
// when idle and steps it through S_MUL1, S_MUL2 and S_CMP on its shared multiplier, and out_valid rises
// from S_CMP of the closing edge; the front takes a new vertex only once its pending edge jobs are queued
// reset: asynchronous active low; clears query point, parity and all control at once
`default_nettype none
module point_in_polygon_ray_cast (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pip_pkg::AddrW-1:0]  paddr,
	input  wire logic [pip_pkg::DataW-1:0]  pwdata,
	output logic      [pip_pkg::DataW-1:0]  prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire pip_pkg::coord_t            vertex_x,
	input  wire pip_pkg::coord_t            vertex_y,
	input  wire logic                       last_vertex,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            inside_res
);

	pip_pkg::coord_t    point_x_q, point_y_q;
	pip_pkg::q_wr_t     q_wr;
	pip_pkg::q_rd_t     q_rd;
	pip_pkg::edge_job_t wr_job, rd_job;
	logic               q_full, pop;
	logic               reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[pip_pkg::AddrW-1];

	always_comb begin
		case (reg_sel)
			pip_pkg::RegPointX: prdata = pip_pkg::DataW'(point_x_q);
			pip_pkg::RegPointY: prdata = pip_pkg::DataW'(point_y_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_sel)
				pip_pkg::RegPointX: point_x_q <= pwdata[pip_pkg::CoordW-1:0];
				pip_pkg::RegPointY: point_y_q <= pwdata[pip_pkg::CoordW-1:0];
				default: ;
			endcase
		end
	end

	pip_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.q_wr        (q_wr),
		.q_full      (q_full),
		.q_job       (wr_job)
	);

	pip_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (pop),
		.q_rd   (q_rd),
		.rd_job (rd_job)
	);

	pip_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.point_x    (point_x_q),
		.point_y    (point_y_q),
		.q_rd       (q_rd),
		.job        (rd_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.inside_res (inside_res)
	);

endmodule
`default_nettype wire

[tb/sv/point_in_polygon_ray_cast_check.sv]
`timescale 1ns / 1ps
// checker: mirrors the query point, predicts the inside flag per polygon and compares result beats
module point_in_polygon_ray_cast_check (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [pip_pkg::AddrW-1:0]  paddr,
	input  wire logic [pip_pkg::DataW-1:0]  pwdata,
	input  wire logic [pip_pkg::DataW-1:0]  prdata,
	input  wire logic                       pready,
	input  wire logic                       in_valid,
	input  wire logic                       in_ready,
	input  wire pip_pkg::coord_t            vertex_x,
	input  wire pip_pkg::coord_t            vertex_y,
	input  wire logic                       last_vertex,
	input  wire logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire logic                       inside_res,
	output int                              fail_count,
	output int                              pending
);
	import pip_pkg::*;

	localparam logic [AddrW-1:0] AddrPointX = AddrW'(int'(RegPointX) * (DataW / 8));
	localparam logic [AddrW-1:0] AddrPointY = AddrW'(int'(RegPointY) * (DataW / 8));

	typedef logic signed [ProdW+1:0] wide_t;

	coord_t point_x;
	coord_t point_y;
	coord_t first_x;
	coord_t first_y;
	coord_t prev_x;
	coord_t prev_y;
	coord_t reg_value;
	logic   parity;
	logic   started;
	logic   inside_bit;
	logic   inside_due[$];

	function automatic bit count_failure();
		fail_count++;
		return fail_count <= 10;
	endfunction

	// one edge of the even-odd test, with the crossing compared by cross-multiplication
	function automatic logic edge_crosses(coord_t qx, coord_t qy, coord_t ax, coord_t ay,
			coord_t bx, coord_t by);
		wide_t px, py, x1, y1, x2, y2, ylo, yhi, xhi, dy;
		px = qx;
		py = qy;
		x1 = ax;
		y1 = ay;
		x2 = bx;
		y2 = by;
		ylo = (y1 < y2) ? y1 : y2;
		yhi = (y1 < y2) ? y2 : y1;
		xhi = (x1 < x2) ? x2 : x1;
		if (!(py > ylo && py <= yhi && px <= xhi))
			return 1'b0;
		dy = y2 - y1;
		if (x1 == x2)
			return 1'b1;
		if (dy > 0)
			return (px - x1) * dy <= (py - y1) * (x2 - x1);
		return (py - y1) * (x2 - x1) <= (px - x1) * dy;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x = '0;
			point_y = '0;
			first_x = '0;
			first_y = '0;
			prev_x  = '0;
			prev_y  = '0;
			parity  = 1'b0;
			started = 1'b0;
			inside_due.delete();
			pending = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == AddrPointX)
						point_x = coord_t'(pwdata[CoordW-1:0]);
					else if (paddr == AddrPointY)
						point_y = coord_t'(pwdata[CoordW-1:0]);
				end else if (paddr == AddrPointX || paddr == AddrPointY) begin
					reg_value = (paddr == AddrPointX) ? point_x : point_y;
					if (coord_t'(prdata[CoordW-1:0]) !== reg_value && count_failure())
						$display("register read at %0d: expected %0d, actual %0d",
							paddr, reg_value, $signed(prdata[CoordW-1:0]));
				end
			end
			if (out_valid && out_ready) begin
				if (inside_due.size() == 0) begin
					if (count_failure())
						$display("inside_res beat with none due: actual %0b", inside_res);
				end else begin
					inside_bit = inside_due.pop_front();
					if (inside_res !== inside_bit && count_failure())
						$display("inside_res mismatch: expected %0b, actual %0b",
							inside_bit, inside_res);
				end
			end
			if (in_valid && in_ready) begin
				if (!started) begin
					first_x = vertex_x;
					first_y = vertex_y;
					parity  = 1'b0;
					started = 1'b1;
				end else begin
					parity ^= edge_crosses(point_x, point_y, prev_x, prev_y,
						vertex_x, vertex_y);
				end
				prev_x = vertex_x;
				prev_y = vertex_y;
				if (last_vertex) begin
					// closing edge back to the first vertex
					parity ^= edge_crosses(point_x, point_y, vertex_x, vertex_y,
						first_x, first_y);
					inside_due.push_back(parity);
					parity  = 1'b0;
					started = 1'b0;
				end
			end
			pending = inside_due.size();
		end
	end

endmodule

[tb/sv/point_in_polygon_ray_cast_tb.sv]
`timescale 1ns / 1ps
// testbench top: drives query points and polygon vertex beats, stalls results, gives the verdict
module point_in_polygon_ray_cast_tb;
	import pip_pkg::*;

	localparam int IdlePct       = 18;
	localparam int LatencyCycles = 32;
	localparam int CycleLimit    = 400000;
	localparam int RandomItems   = 1150;

	localparam logic [AddrW-1:0] AddrPointX = AddrW'(int'(RegPointX) * (DataW / 8));
	localparam logic [AddrW-1:0] AddrPointY = AddrW'(int'(RegPointY) * (DataW / 8));
	localparam coord_t MaxC = {1'b0, {(CoordW-1){1'b1}}};
	localparam coord_t MinC = {1'b1, {(CoordW-1){1'b0}}};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [AddrW-1:0]   paddr = '0;
	logic [DataW-1:0]   pwdata = '0;
	logic [DataW-1:0]   prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	coord_t             vertex_x = '0;
	coord_t             vertex_y = '0;
	logic               last_vertex = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               inside_res;

	bit     steady = 1'b0;
	int     fail_count;
	int     pending;
	int     sent_count = 0;
	int     cycle_count = 0;
	coord_t query_x = '0;
	coord_t query_y = '0;

	point_in_polygon_ray_cast i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.inside_res  (inside_res)
	);

	point_in_polygon_ray_cast_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.inside_res  (inside_res),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(99) >= IdlePct);
	end

	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[point_in_polygon_ray_cast] ERROR");
		$finish;
	end

	function automatic coord_t near(coord_t base, int span);
		return base + coord_t'(int'($urandom_range(2 * span)) - span);
	endfunction

	function automatic coord_t pick_extreme(coord_t q);
		case ($urandom_range(5))
			0: return MinC;
			1: return MaxC;
			2: return q;
			3: return q + 1;
			4: return q - 1;
			default: return '0;
		endcase
	endfunction

	function automatic coord_t pick_query();
		case ($urandom_range(4))
			0: return MaxC;
			1: return MinC;
			2: return '0;
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic stop_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		stop_input();
		while (pending != 0)
			@(negedge clk);
		repeat (LatencyCycles) @(negedge clk);
	endtask

	task automatic apb_access(input logic write, input logic [AddrW-1:0] addr, input coord_t data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write;
		paddr   <= addr;
		pwdata  <= DataW'(data);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_point(input coord_t x, input coord_t y);
		wait_idle();
		query_x = x;
		query_y = y;
		apb_access(1'b1, AddrPointX, x);
		apb_access(1'b1, AddrPointY, y);
		apb_access(1'b0, AddrPointX, '0);
		apb_access(1'b0, AddrPointY, '0);
	endtask

	task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IdlePct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		vertex_x    <= x;
		vertex_y    <= y;
		last_vertex <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	initial begin
		int     base;
		int     nverts;
		int     shape;
		int     split;
		coord_t vx;
		coord_t vy;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// query point still at its reset value of the origin
		apb_access(1'b0, AddrPointX, '0);
		apb_access(1'b0, AddrPointY, '0);
		// single vertex polygon
		send_vertex(5, 5, 1'b1);
		send_vertex(-10, -10, 1'b0);
		send_vertex(10, -10, 1'b0);
		send_vertex(10, 10, 1'b0);
		send_vertex(-10, 10, 1'b1);
		// horizontal base edge through the point
		send_vertex(0, 0, 1'b0);
		send_vertex(10, 0, 1'b0);
		send_vertex(5, 10, 1'b1);
		send_vertex(MinC, MinC, 1'b0);
		send_vertex(MaxC, MinC, 1'b0);
		send_vertex(MaxC, MaxC, 1'b0);
		send_vertex(MinC, MaxC, 1'b1);
		// vertical edge on the point
		send_vertex(0, -5, 1'b0);
		send_vertex(0, 5, 1'b0);
		send_vertex(-4, 0, 1'b1);
		send_vertex(-5, 0, 1'b0);
		send_vertex(5, 0, 1'b1);
		set_point(MaxC, MinC);
		send_vertex(MinC, MaxC, 1'b0);
		send_vertex(MaxC, MaxC, 1'b0);
		send_vertex(MaxC, MinC + 1, 1'b0);
		send_vertex(MinC, MinC, 1'b1);
		// query point moves in the middle of a polygon
		set_point(0, 0);
		send_vertex(-10, -10, 1'b0);
		send_vertex(10, -10, 1'b0);
		set_point(20, 0);
		send_vertex(10, 10, 1'b0);
		send_vertex(-10, 10, 1'b1);

		base = sent_count;
		while (sent_count - base < RandomItems) begin
			set_point(pick_query(), pick_query());
			repeat ($urandom_range(6, 16)) begin
				steady = (sent_count - base >= 400) && (sent_count - base < 600);
				case ($urandom_range(19))
					0: nverts = $urandom_range(1, 2);
					1: nverts = $urandom_range(9, 24);
					default: nverts = $urandom_range(3, 8);
				endcase
				shape = $urandom_range(4);
				split = 0;
				if (nverts > 1 && $urandom_range(29) == 0)
					split = $urandom_range(1, nverts - 1);
				vx = query_x;
				vy = query_y;
				for (int k = 0; k < nverts; k++) begin
					if (split != 0 && k == split)
						set_point(near(query_x, 8), near(query_y, 8));
					case (shape)
						0: begin
							vx = near(query_x, 8);
							vy = near(query_y, 8);
						end
						1: begin
							vx = near(query_x, 1 << 19);
							vy = near(query_y, 1 << 19);
						end
						2: begin
							vx = coord_t'($urandom);
							vy = coord_t'($urandom);
						end
						3: begin
							vx = pick_extreme(query_x);
							vy = pick_extreme(query_y);
						end
						default: begin
							// axis-aligned steps give vertical and horizontal edges
							if ($urandom_range(1))
								vx = near(query_x, 4);
							else
								vy = near(query_y, 4);
						end
					endcase
					send_vertex(vx, vy, k == nverts - 1);
				end
			end
		end
		steady = 1'b0;

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("[point_in_polygon_ray_cast] OK");
		else
			$display("[point_in_polygon_ray_cast] ERROR");
		$finish;
	end

endmodule
